FILE: sv/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared definitions for the 2x2 mip downscaler
// Sizes, register indexes and the control bundle that drives one channel lane.
// ----------------------------------------------------------------------------
package mbd_pkg;

	// Largest source width held by the line buffer
	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int LINE_DEPTH   = MAX_WIDTH / 2;

	// Channel and sum widths
	localparam int CH_W   = 8;
	localparam int SUM_W  = CH_W + 1;
	localparam int LANES  = 4;
	localparam int LINE_W = LANES * SUM_W;

	// Register file
	localparam int CFG_W   = 13;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam logic REG_SOURCE_WIDTH  = 1'b0;
	localparam logic REG_SOURCE_HEIGHT = 1'b1;

	// Counter and size widths
	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WID_W = COL_W + 1;
	localparam int ROW_W = $clog2(HEIGHT_LIMIT);
	localparam int HGT_W = ROW_W + 1;
	localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// Per-transfer control shared by all four channel lanes
	typedef struct packed {
		logic hold_en;   // capture even-column texel
		logic pair_en;   // capture pair sum into stage 1
		logic w_one;     // single-column source: texel counts twice
		logic h_one_s1;  // single-row source: pair is its own partner
	} lane_ctrl_t;

endpackage

FILE: sv/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane: one color channel of the downscaler
// Holds the left texel, forms the horizontal pair sum, and averages it with
// the pair from the line above into a rounded unorm8 value.
// ----------------------------------------------------------------------------
module mbd_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mbd_pkg::lane_ctrl_t        ctrl,
	input  logic [mbd_pkg::CH_W-1:0]   texel,
	input  logic [mbd_pkg::SUM_W-1:0]  line_sum,
	output logic [mbd_pkg::SUM_W-1:0]  pair,
	output logic [mbd_pkg::CH_W-1:0]   avg
);

	logic [mbd_pkg::CH_W-1:0]  hold_q;
	logic [mbd_pkg::SUM_W-1:0] pair_s1;
	logic [mbd_pkg::SUM_W-1:0] other;
	logic [mbd_pkg::SUM_W:0]   total;

	// Even-column texel waits here for its right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (ctrl.hold_en) begin
			hold_q <= texel;
		end
	end

	// Horizontal pair: doubled texel when the source is one column wide
	assign pair = ctrl.w_one ? {texel, 1'b0}
	                         : mbd_pkg::SUM_W'(hold_q) + mbd_pkg::SUM_W'(texel);

	always_ff @(posedge clk) begin
		if (ctrl.pair_en) begin
			pair_s1 <= pair;
		end
	end

	// Vertical combine with rounding: (four texels + 2) >> 2
	assign other = ctrl.h_one_s1 ? pair_s1 : line_sum;
	assign total = (mbd_pkg::SUM_W+1)'(pair_s1) + (mbd_pkg::SUM_W+1)'(other)
	             + (mbd_pkg::SUM_W+1)'(2);
	assign avg   = total[mbd_pkg::SUM_W:2];

endmodule

FILE: sv/mbd_line_buf.sv
// ----------------------------------------------------------------------------
// mbd_line_buf: line of pair sums from the even source row
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mbd_line_buf (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [mbd_pkg::IDX_W-1:0]   wr_addr,
	input  logic [mbd_pkg::LINE_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [mbd_pkg::IDX_W-1:0]   rd_addr,
	output logic [mbd_pkg::LINE_W-1:0]  rd_data
);

	logic [mbd_pkg::LINE_W-1:0] mem [mbd_pkg::LINE_DEPTH];
	logic [mbd_pkg::LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/mip_box_downscale_rgba8_top.sv
// ----------------------------------------------------------------------------
// mip_box_downscale_rgba8_top: 2x2 box mip downscaler for RGBA8 unorm
// Source texels in raster order, next mip level out in raster order.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_red, in_green, in_blue, in_alpha
//   out      output     out_valid/out_stall out_red..out_alpha, last_texel
//   cfg      input      APB psel/penable   source_width @0x0, source_height @0x4
//
// One texel is taken per cycle while in_stall is low; the result of the texel
// that completes it passes stage 1 (line buffer read), then the output register.
// Four channel lanes run in parallel; the output stage merges them.
// Reset sets both sizes to 1 and the position to the image start.
// A stalled output holds one result while one more waits in stage 1; the
// input stalls only when both are full. Writing either size restarts the image.
// ----------------------------------------------------------------------------
module mip_box_downscale_rgba8_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// source texels
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mbd_pkg::CH_W-1:0]      in_red,
	input  logic [mbd_pkg::CH_W-1:0]      in_green,
	input  logic [mbd_pkg::CH_W-1:0]      in_blue,
	input  logic [mbd_pkg::CH_W-1:0]      in_alpha,
	// destination texels
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbd_pkg::CH_W-1:0]      out_red,
	output logic [mbd_pkg::CH_W-1:0]      out_green,
	output logic [mbd_pkg::CH_W-1:0]      out_blue,
	output logic [mbd_pkg::CH_W-1:0]      out_alpha,
	output logic                          last_texel,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0]    paddr,
	input  logic [mbd_pkg::DATA_W-1:0]    pwdata,
	output logic [mbd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [mbd_pkg::CFG_W-1:0]  cfg_w_q, cfg_h_q;
	logic [mbd_pkg::WID_W-1:0]  eff_w, w_even, dw;
	logic [mbd_pkg::HGT_W-1:0]  eff_h, h_even, dh;
	logic                       w_one, h_one;
	logic [mbd_pkg::COL_W-1:0]  col_q, k;
	logic [mbd_pkg::ROW_W-1:0]  row_q;
	logic                       cfg_wr, in_acc;
	logic                       col_used, row_used, pair_valid, emit;
	logic                       wr_en, rd_en, last_col, last_row;
	logic [mbd_pkg::IDX_W-1:0]  idx;
	logic                       s1_valid_q, last_s1, h_one_s1, s1_move;
	mbd_pkg::lane_ctrl_t        ctrl;
	logic [mbd_pkg::LINE_W-1:0] pair_all, line_rd;
	logic [mbd_pkg::CH_W-1:0]   avg [mbd_pkg::LANES];
	logic [mbd_pkg::CH_W-1:0]   texel [mbd_pkg::LANES];
	logic                       out_valid_q, last_q;
	logic [mbd_pkg::CH_W-1:0]   out_ch_q [mbd_pkg::LANES];

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= mbd_pkg::CFG_W'(1);
			cfg_h_q <= mbd_pkg::CFG_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				mbd_pkg::REG_SOURCE_WIDTH:  cfg_w_q <= pwdata[mbd_pkg::CFG_W-1:0];
				mbd_pkg::REG_SOURCE_HEIGHT: cfg_h_q <= pwdata[mbd_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mbd_pkg::REG_SOURCE_WIDTH:  prdata = mbd_pkg::DATA_W'(cfg_w_q);
			mbd_pkg::REG_SOURCE_HEIGHT: prdata = mbd_pkg::DATA_W'(cfg_h_q);
			default:                    prdata = '0;
		endcase
	end

	// Effective sizes: zero reads as one, oversize is clamped
	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = mbd_pkg::WID_W'(1);
		end else if (32'(cfg_w_q) > mbd_pkg::MAX_WIDTH) begin
			eff_w = mbd_pkg::WID_W'(mbd_pkg::MAX_WIDTH);
		end else begin
			eff_w = mbd_pkg::WID_W'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			eff_h = mbd_pkg::HGT_W'(1);
		end else if (32'(cfg_h_q) > mbd_pkg::HEIGHT_LIMIT) begin
			eff_h = mbd_pkg::HGT_W'(mbd_pkg::HEIGHT_LIMIT);
		end else begin
			eff_h = mbd_pkg::HGT_W'(cfg_h_q);
		end
	end

	assign w_one  = (eff_w == mbd_pkg::WID_W'(1));
	assign h_one  = (eff_h == mbd_pkg::HGT_W'(1));
	assign w_even = {eff_w[mbd_pkg::WID_W-1:1], 1'b0};
	assign h_even = {eff_h[mbd_pkg::HGT_W-1:1], 1'b0};
	assign dw     = w_one ? mbd_pkg::WID_W'(1) : (eff_w >> 1);
	assign dh     = h_one ? mbd_pkg::HGT_W'(1) : (eff_h >> 1);

	// Position decode for the current texel
	assign in_acc     = in_valid && !in_stall;
	assign col_used   = w_one || (mbd_pkg::WID_W'(col_q) < w_even);
	assign row_used   = h_one || (mbd_pkg::HGT_W'(row_q) < h_even);
	assign pair_valid = in_acc && col_used && row_used && (w_one || col_q[0]);
	assign wr_en      = pair_valid && !h_one && !row_q[0];
	assign rd_en      = pair_valid && !h_one && row_q[0];
	assign emit       = pair_valid && (h_one || row_q[0]);
	assign k          = col_q >> 1;
	assign idx        = mbd_pkg::IDX_W'(k);
	assign last_col   = (mbd_pkg::WID_W'(k) == dw - mbd_pkg::WID_W'(1));
	assign last_row   = (mbd_pkg::HGT_W'(row_q >> 1) == dh - mbd_pkg::HGT_W'(1));

	// Raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (mbd_pkg::WID_W'(col_q) + mbd_pkg::WID_W'(1) >= eff_w) begin
				col_q <= '0;
				if (mbd_pkg::HGT_W'(row_q) + mbd_pkg::HGT_W'(1) >= eff_h) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + mbd_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + mbd_pkg::COL_W'(1);
			end
		end
	end

	// Stage 1 holds one emitting transfer while the line buffer read lands
	assign s1_move  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= emit;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_s1  <= last_col && (h_one || last_row);
			h_one_s1 <= h_one;
		end
	end

	// Channel lanes
	assign ctrl.hold_en  = in_acc && col_used && row_used && !w_one && !col_q[0];
	assign ctrl.pair_en  = emit || wr_en;
	assign ctrl.w_one    = w_one;
	assign ctrl.h_one_s1 = h_one_s1;

	assign texel[0] = in_red;
	assign texel[1] = in_green;
	assign texel[2] = in_blue;
	assign texel[3] = in_alpha;

	for (genvar i = 0; i < mbd_pkg::LANES; i++) begin : g_lane
		mbd_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.texel    (texel[i]),
			.line_sum (line_rd[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]),
			.pair     (pair_all[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]),
			.avg      (avg[i])
		);
	end

	mbd_line_buf u_line_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx),
		.wr_data (pair_all),
		.rd_en   (rd_en),
		.rd_addr (idx),
		.rd_data (line_rd)
	);

	// Merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_ch_q <= avg;
			last_q   <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_ch_q[0];
	assign out_green  = out_ch_q[1];
	assign out_blue   = out_ch_q[2];
	assign out_alpha  = out_ch_q[3];
	assign last_texel = last_q;

`ifndef ASSERT_OFF
	// Even rows write the line, odd rows read it: never both at once
	a_line_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("line buffer read and write in the same cycle");

	// A full pipeline with a stalled output must stall the input
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && out_stall) |-> !in_acc)
		else $error("transfer accepted with pipeline full");

	// Stage 1 result reaches the output register when it moves
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid_q)
		else $error("stage 1 result lost");

	// Column stays inside the effective width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		mbd_pkg::WID_W'(col_q) < eff_w)
		else $error("column counter out of range");

	// Row stays inside the effective height
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		mbd_pkg::HGT_W'(row_q) < eff_h)
		else $error("row counter out of range");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2x2 RGBA8 mip downscaler
// A directed table covers reset state, zero and odd sizes, single-row and
// single-column clamping, restart on a size write, channel extremes and
// rounding. Random images follow under four idle/stall mixes. Every output
// transfer is checked against the result typed into the table or an in-bench box filter model.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned PHASE_TEXELS    = 400;
	localparam int unsigned OVERSIZE_TEXELS = 48;
	localparam int          DIR_ROWS        = 38;

	// Lane 0 is red, lane 3 is alpha; hex literals read alpha:blue:green:red
	typedef logic [mbd_pkg::LANES-1:0][mbd_pkg::CH_W-1:0] texel_t;

	typedef struct packed {
		texel_t px;
		logic   last_flag;
	} texel_out_t;

	// Result typed into the table, travels in order with its texel
	typedef struct packed {
		logic       known;
		texel_out_t res;
	} typed_note_t;

	typedef enum logic {ROW_TEXEL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        reg_sel;
		logic [31:0] value;
		texel_t      px;
		logic        known;
		texel_out_t  res;
	} stim_row_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [mbd_pkg::CH_W-1:0]     in_red     = '0;
	logic [mbd_pkg::CH_W-1:0]     in_green   = '0;
	logic [mbd_pkg::CH_W-1:0]     in_blue    = '0;
	logic [mbd_pkg::CH_W-1:0]     in_alpha   = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic [mbd_pkg::CH_W-1:0]     out_red;
	logic [mbd_pkg::CH_W-1:0]     out_green;
	logic [mbd_pkg::CH_W-1:0]     out_blue;
	logic [mbd_pkg::CH_W-1:0]     out_alpha;
	logic                         last_texel;
	logic                         psel       = 1'b0;
	logic                         penable    = 1'b0;
	logic                         pwrite     = 1'b0;
	logic [mbd_pkg::ADDR_W-1:0]   paddr      = '0;
	logic [mbd_pkg::DATA_W-1:0]   pwdata     = '0;
	logic [mbd_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	// Model state: registers, line of pair sums, held texel, position
	logic [mbd_pkg::CFG_W-1:0]    size_w = mbd_pkg::CFG_W'(1);
	logic [mbd_pkg::CFG_W-1:0]    size_h = mbd_pkg::CFG_W'(1);
	logic [mbd_pkg::LANES-1:0][mbd_pkg::SUM_W-1:0] line_sums [mbd_pkg::LINE_DEPTH];
	texel_t                       held_left = '0;
	int unsigned                  col_pos = 0;
	int unsigned                  row_pos = 0;

	texel_out_t   pending_texels [$];
	typed_note_t  typed_q [$];
	int unsigned  sent_texels  = 0;
	int unsigned  mismatches   = 0;
	int unsigned  cycle_count  = 0;
	int unsigned  idle_pct     = 0;
	int unsigned  stall_pct    = 0;
	stim_row_t    dir_rows [DIR_ROWS];

	mip_box_downscale_rgba8_top DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Effective size after zero and oversize clamping
	function automatic int unsigned eff_size(logic [mbd_pkg::CFG_W-1:0] v, int unsigned cap);
		int unsigned s;
		s = 32'(v);
		if (s == 0) s = 1;
		if (s > cap) s = cap;
		return s;
	endfunction

	// Box filter model: one accepted texel in, at most one result out
	function automatic bit downscale_step(input texel_t px, output texel_out_t res);
		int unsigned w, h, dw, dh, k;
		logic [mbd_pkg::LANES-1:0][mbd_pkg::SUM_W-1:0] pair, other;
		logic [mbd_pkg::SUM_W:0] s;
		bit done, emit, fin;
		w = eff_size(size_w, mbd_pkg::MAX_WIDTH);
		h = eff_size(size_h, mbd_pkg::HEIGHT_LIMIT);
		dw = (w >= 2) ? w / 2 : 1;
		dh = (h >= 2) ? h / 2 : 1;
		res = '0;
		pair = '0;
		other = '0;
		k = 0;
		done = 0;
		emit = 0;
		fin = 0;
		if ((w == 1 || col_pos < 2 * dw) && (h == 1 || row_pos < 2 * dh)) begin
			// horizontal pair: clamp, hold even column, or sum with held
			if (w == 1) begin
				for (int i = 0; i < mbd_pkg::LANES; i++) pair[i] = {px[i], 1'b0};
				done = 1;
			end else if (col_pos[0] == 1'b0) begin
				held_left = px;
			end else begin
				for (int i = 0; i < mbd_pkg::LANES; i++)
					pair[i] = {1'b0, held_left[i]} + {1'b0, px[i]};
				k = col_pos / 2;
				done = 1;
			end
			// vertical pair: clamp, park in line, or merge with line
			if (done) begin
				if (h == 1) begin
					other = pair;
					emit = 1;
					fin = (k == dw - 1);
				end else if (row_pos[0] == 1'b0) begin
					line_sums[k] = pair;
				end else begin
					other = line_sums[k];
					emit = 1;
					fin = (k == dw - 1) && (row_pos / 2 == dh - 1);
				end
			end
			if (emit) begin
				for (int i = 0; i < mbd_pkg::LANES; i++) begin
					s = (mbd_pkg::SUM_W+1)'({1'b0, pair[i]} + {1'b0, other[i]} + 2);
					res.px[i] = s[mbd_pkg::SUM_W:2];
				end
				res.last_flag = fin;
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
		return emit;
	endfunction

	function automatic stim_row_t cfg_row(logic sel, logic [31:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.reg_sel = sel;
		row.value = value;
		return row;
	endfunction

	function automatic stim_row_t texel_row(texel_t px);
		stim_row_t row;
		row = '0;
		row.kind = ROW_TEXEL;
		row.px = px;
		return row;
	endfunction

	function automatic stim_row_t known_row(texel_t px, texel_t res_px, logic fin);
		stim_row_t row;
		row = texel_row(px);
		row.known = 1'b1;
		row.res = {res_px, fin};
		return row;
	endfunction

	// Mostly tiny sizes, sometimes zero or mid-size; junk above bit 12
	function automatic logic [31:0] random_size();
		int unsigned pick;
		logic [31:0] v;
		pick = $urandom_range(0, 15);
		if (pick == 0) v = 0;
		else if (pick == 1) v = $urandom_range(9, 40);
		else v = $urandom_range(1, 8);
		return ($urandom() & 32'hFFFF_E000) | v;
	endfunction

	function automatic texel_t random_texel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// One source transfer, with random idle cycles ahead of it
	task automatic send_texel(input texel_t px, input logic known, input texel_out_t res);
		typed_note_t note;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		note.known = known;
		note.res   = res;
		typed_q = {typed_q, note};
		sent_texels++;
		in_valid <= 1'b1;
		in_red   <= px[0];
		in_green <= px[1];
		in_blue  <= px[2];
		in_alpha <= px[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic stream_texels(input int unsigned count);
		texel_out_t blank;
		blank = '0;
		repeat (count) send_texel(random_texel(), 1'b0, blank);
	endtask

	// Block goes quiet: all results in, pipeline flushed
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver stall pattern
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Track register writes and accepted texels, queue expected results
	always @(posedge clk) begin
		typed_note_t note;
		texel_out_t  res;
		if (arst_n && psel && penable && pwrite && pready) begin
			if (paddr[mbd_pkg::ADDR_W-1:2] == mbd_pkg::REG_SOURCE_WIDTH)
				size_w = pwdata[mbd_pkg::CFG_W-1:0];
			else
				size_h = pwdata[mbd_pkg::CFG_W-1:0];
			col_pos = 0;
			row_pos = 0;
		end
		if (arst_n && in_valid && !in_stall) begin
			note = typed_q.pop_front();
			if (downscale_step({in_alpha, in_blue, in_green, in_red}, res) && !note.known)
				pending_texels = {pending_texels, res};
			if (note.known)
				pending_texels = {pending_texels, note.res};
		end
	end

	// Compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		texel_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_texels.size() == 0) begin
				$error("output transfer with no expected texel pending");
				mismatches++;
			end else begin
				e = pending_texels.pop_front();
				if (out_red !== e.px[0]) begin
					$error("out_red: expected %02h, got %02h", e.px[0], out_red);
					mismatches++;
				end
				if (out_green !== e.px[1]) begin
					$error("out_green: expected %02h, got %02h", e.px[1], out_green);
					mismatches++;
				end
				if (out_blue !== e.px[2]) begin
					$error("out_blue: expected %02h, got %02h", e.px[2], out_blue);
					mismatches++;
				end
				if (out_alpha !== e.px[3]) begin
					$error("out_alpha: expected %02h, got %02h", e.px[3], out_alpha);
					mismatches++;
				end
				if (last_texel !== e.last_flag) begin
					$error("last_texel: expected %0b, got %0b", e.last_flag, last_texel);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned size, start, pick, rem, n;
		dir_rows = '{
			// after reset the image is 1x1: texel passes through
			known_row(32'hFF00FF00, 32'hFF00FF00, 1'b1),
			known_row(32'h01807FFE, 32'h01807FFE, 1'b1),
			// 2x2 at full scale
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd2),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd2),
			texel_row(32'hFFFFFFFF),
			texel_row(32'hFFFFFFFF),
			texel_row(32'hFFFFFFFF),
			known_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1),
			// zero sizes act as 1
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd0),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd0),
			known_row(32'h55AA00FF, 32'h55AA00FF, 1'b1),
			// 3x3: last column and row dropped
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd3),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd3),
			texel_row(32'h10203040),
			texel_row(32'h50607080),
			texel_row(32'hDEADBEEF),
			texel_row(32'h0F0E0D0C),
			texel_row(32'h01020304),
			texel_row(32'hC0FFEE00),
			texel_row(32'h11111111),
			texel_row(32'h22222222),
			texel_row(32'h33333333),
			// single row: pair sum counts twice
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd2),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd1),
			texel_row(32'h02000001),
			texel_row(32'h03000100),
			// single column: texel counts twice
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd1),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd2),
			texel_row(32'h0100FF80),
			texel_row(32'h0201007F),
			// restart mid-image, then rounding on small sums
			cfg_row(mbd_pkg::REG_SOURCE_WIDTH, 32'd2),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd2),
			texel_row(32'hFFFFFFFF),
			cfg_row(mbd_pkg::REG_SOURCE_HEIGHT, 32'd2),
			texel_row(32'h00000001),
			texel_row(32'h00000101),
			texel_row(32'h00010000),
			texel_row(32'h02010100)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[n]) begin
			if (dir_rows[n].kind == ROW_CFG) begin
				wait_drained();
				reg_write(dir_rows[n].reg_sel, dir_rows[n].value);
			end else begin
				send_texel(dir_rows[n].px, dir_rows[n].known, dir_rows[n].res);
			end
		end

		// Random images under four idle/stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			if (phase == 0) begin
				// oversize width on part of a row, then oversize height on part of a column
				wait_drained();
				reg_write(mbd_pkg::REG_SOURCE_WIDTH, 32'h0000_1FFF);
				reg_write(mbd_pkg::REG_SOURCE_HEIGHT, 32'd1);
				stream_texels(OVERSIZE_TEXELS);
				wait_drained();
				reg_write(mbd_pkg::REG_SOURCE_WIDTH, 32'd1);
				reg_write(mbd_pkg::REG_SOURCE_HEIGHT, 32'hFFFF_FFFF);
				stream_texels(OVERSIZE_TEXELS);
			end
			start = sent_texels;
			while (sent_texels - start < PHASE_TEXELS) begin
				wait_drained();
				pick = $urandom_range(0, 3);
				if (pick != 2) reg_write(mbd_pkg::REG_SOURCE_WIDTH, random_size());
				if (pick != 1) reg_write(mbd_pkg::REG_SOURCE_HEIGHT, random_size());
				size = eff_size(size_w, mbd_pkg::MAX_WIDTH) *
				       eff_size(size_h, mbd_pkg::HEIGHT_LIMIT);
				// whole images, trimmed to what is left of the phase
				rem = PHASE_TEXELS - (sent_texels - start);
				n = size * $urandom_range(1, 3);
				stream_texels((n < rem) ? n : rem);
				// occasionally cut an image short before the next size write
				if (size > 1 && $urandom_range(0, 3) == 0)
					stream_texels($urandom_range(1, (size > 16) ? 16 : size - 1));
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
